// ===== hw/rtl/latency_stats_accumulator_macros.svh =====
// Assertion helpers for the latency statistics block.
`ifndef LATENCY_STATS_ACCUMULATOR_MACROS_SVH
`define LATENCY_STATS_ACCUMULATOR_MACROS_SVH

// Check a same-cycle implication, quiet while reset is held.
`define LSA_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("latency stats: same-cycle check failed");

// Check an implication in the following cycle, quiet while reset is held.
`define LSA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("latency stats: next-cycle check failed");

`endif

// ===== hw/rtl/lsa_pkg.sv =====
package lsa_pkg;

    localparam int ACT_W      = 3;
    localparam int RTT_W      = 32;
    localparam int MEAN_W     = 40;
    localparam int OUT_CNT_W  = 32;
    localparam int CNT_EXT_W  = 64;
    localparam int STEP_W     = $clog2(MEAN_W);
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 304;

    typedef enum logic [ACT_W-1:0] {
        ACT_RECV    = 3'd0,
        ACT_DROP    = 3'd1,
        ACT_TIMEOUT = 3'd2,
        ACT_SEQERR  = 3'd3,
        ACT_STALE   = 3'd4,
        ACT_SENT    = 3'd5
    } act_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_UPDATE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic div_step;
        logic update;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic need_div;
    } sts_t;

    // First member lands in the top bits: this order matches m_tdata.
    typedef struct packed {
        logic                  lat_valid;
        logic [MEAN_W-1:0]     lat_mean;
        logic [RTT_W-1:0]      lat_max;
        logic [RTT_W-1:0]      lat_min;
        logic [OUT_CNT_W-1:0]  count_stale;
        logic [OUT_CNT_W-1:0]  count_seq_errors;
        logic [OUT_CNT_W-1:0]  count_timeouts;
        logic [OUT_CNT_W-1:0]  count_dropped;
        logic [OUT_CNT_W-1:0]  count_sent;
        logic [OUT_CNT_W-1:0]  count_received;
    } stats_t;

endpackage

// ===== hw/rtl/lsa_ctrl.sv =====
module lsa_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    input  logic          out_free,
    input  lsa_pkg::sts_t sts,
    output logic          s_tready,
    output lsa_pkg::cmd_t cmd
);

    lsa_pkg::state_t               state_reg, state_next;
    logic [lsa_pkg::STEP_W-1:0]    step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lsa_pkg::ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            lsa_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = lsa_pkg::ST_EXEC;
            end
            lsa_pkg::ST_EXEC: begin
                step_next  = '0;
                state_next = sts.need_div ? lsa_pkg::ST_DIV : lsa_pkg::ST_EMIT;
            end
            lsa_pkg::ST_DIV: begin
                step_next = step_reg + lsa_pkg::STEP_W'(1);
                if (step_reg == lsa_pkg::STEP_W'(lsa_pkg::MEAN_W - 1))
                    state_next = lsa_pkg::ST_UPDATE;
            end
            lsa_pkg::ST_UPDATE: begin
                state_next = lsa_pkg::ST_EMIT;
            end
            lsa_pkg::ST_EMIT: begin
                if (out_free) state_next = lsa_pkg::ST_IDLE;
            end
            default: begin
                state_next = lsa_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready     = 1'b0;
        cmd          = '0;
        case (state_reg)
            lsa_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            lsa_pkg::ST_EXEC:   cmd.exec     = 1'b1;
            lsa_pkg::ST_DIV:    cmd.div_step = 1'b1;
            lsa_pkg::ST_UPDATE: cmd.update   = 1'b1;
            lsa_pkg::ST_EMIT:   cmd.emit     = out_free;
            default: ;
        endcase
    end

endmodule

// ===== hw/rtl/lsa_dp.sv =====
module lsa_dp #(
    parameter int FRAC_BITS   = 8,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  lsa_pkg::cmd_t               cmd,
    input  logic [lsa_pkg::ACT_W-1:0]   in_action,
    input  logic [lsa_pkg::RTT_W-1:0]   in_rtt,
    output lsa_pkg::sts_t               sts,
    output lsa_pkg::stats_t             stats
);

    localparam int MW   = lsa_pkg::MEAN_W;
    localparam int RW   = lsa_pkg::RTT_W;
    localparam int CW   = COUNT_WIDTH;
    localparam int SH_W = MW + RW;

    logic [lsa_pkg::ACT_W-1:0] action_reg, action_next;
    logic [RW-1:0]             rtt_reg, rtt_next;
    logic [CW-1:0]             recv_reg, recv_next;
    logic [CW-1:0]             sent_reg, sent_next;
    logic [CW-1:0]             drop_reg, drop_next;
    logic [CW-1:0]             tmo_reg, tmo_next;
    logic [CW-1:0]             seq_reg, seq_next;
    logic [CW-1:0]             stale_reg, stale_next;
    logic [RW-1:0]             min_reg, min_next;
    logic [RW-1:0]             max_reg, max_next;
    logic [MW-1:0]             mean_reg, mean_next;
    logic                      seen_reg, seen_next;
    logic                      neg_reg, neg_next;
    logic [CW-1:0]             rem_reg, rem_next;
    logic [MW-1:0]             quo_reg, quo_next;
    logic [CW-1:0]             divisor_reg, divisor_next;

    logic [SH_W-1:0]           shifted;
    logic [MW-1:0]             scaled;
    logic [CW:0]               trial;
    logic [CW:0]               trial_diff;
    logic                      trial_ge;

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
        return (&v) ? v : v + CW'(1);
    endfunction

    function automatic logic [lsa_pkg::OUT_CNT_W-1:0] low_bits(input logic [CW-1:0] v);
        logic [lsa_pkg::CNT_EXT_W-1:0] e;
        e = lsa_pkg::CNT_EXT_W'(v);
        return e[lsa_pkg::OUT_CNT_W-1:0];
    endfunction

    // Scale to fixed point; clamp when the shifted sample overflows the mean width.
    assign shifted = SH_W'(rtt_reg) << FRAC_BITS;
    assign scaled  = (|shifted[SH_W-1:MW]) ? '1 : shifted[MW-1:0];

    // One restoring division step: shift in the next dividend bit, try subtract.
    assign trial      = {rem_reg, quo_reg[MW-1]};
    assign trial_diff = trial - {1'b0, divisor_reg};
    assign trial_ge   = (trial >= {1'b0, divisor_reg});

    assign sts.need_div = (action_reg == lsa_pkg::ACT_RECV) && seen_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            recv_reg  <= '0;
            sent_reg  <= '0;
            drop_reg  <= '0;
            tmo_reg   <= '0;
            seq_reg   <= '0;
            stale_reg <= '0;
            min_reg   <= '0;
            max_reg   <= '0;
            mean_reg  <= '0;
            seen_reg  <= 1'b0;
        end else begin
            recv_reg  <= recv_next;
            sent_reg  <= sent_next;
            drop_reg  <= drop_next;
            tmo_reg   <= tmo_next;
            seq_reg   <= seq_next;
            stale_reg <= stale_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
            mean_reg  <= mean_next;
            seen_reg  <= seen_next;
        end
    end

    always_ff @(posedge aclk) begin
        action_reg  <= action_next;
        rtt_reg     <= rtt_next;
        neg_reg     <= neg_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
    end

    always_comb begin
        action_next  = action_reg;
        rtt_next     = rtt_reg;
        recv_next    = recv_reg;
        sent_next    = sent_reg;
        drop_next    = drop_reg;
        tmo_next     = tmo_reg;
        seq_next     = seq_reg;
        stale_next   = stale_reg;
        min_next     = min_reg;
        max_next     = max_reg;
        mean_next    = mean_reg;
        seen_next    = seen_reg;
        neg_next     = neg_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;

        if (cmd.load) begin
            action_next = in_action;
            rtt_next    = in_rtt;
        end

        if (cmd.exec) begin
            case (action_reg)
                lsa_pkg::ACT_RECV: begin
                    recv_next = sat_inc(recv_reg);
                    if (!seen_reg) begin
                        min_next  = rtt_reg;
                        max_next  = rtt_reg;
                        mean_next = scaled;
                        seen_next = 1'b1;
                    end else begin
                        if (rtt_reg < min_reg) min_next = rtt_reg;
                        if (rtt_reg > max_reg) max_next = rtt_reg;
                        // Load the divider with |sample - mean| over the new count.
                        neg_next     = (scaled < mean_reg);
                        quo_next     = (scaled < mean_reg) ? (mean_reg - scaled)
                                                           : (scaled - mean_reg);
                        rem_next     = '0;
                        divisor_next = sat_inc(recv_reg);
                    end
                end
                lsa_pkg::ACT_DROP:    drop_next  = sat_inc(drop_reg);
                lsa_pkg::ACT_TIMEOUT: tmo_next   = sat_inc(tmo_reg);
                lsa_pkg::ACT_SEQERR:  seq_next   = sat_inc(seq_reg);
                lsa_pkg::ACT_STALE:   stale_next = sat_inc(stale_reg);
                lsa_pkg::ACT_SENT:    sent_next  = sat_inc(sent_reg);
                default: ;
            endcase
        end

        if (cmd.div_step) begin
            rem_next = trial_ge ? trial_diff[CW-1:0] : trial[CW-1:0];
            quo_next = {quo_reg[MW-2:0], trial_ge};
        end

        if (cmd.update) begin
            mean_next = neg_reg ? (mean_reg - quo_reg) : (mean_reg + quo_reg);
        end
    end

    always_comb begin
        stats.count_received   = low_bits(recv_reg);
        stats.count_sent       = low_bits(sent_reg);
        stats.count_dropped    = low_bits(drop_reg);
        stats.count_timeouts   = low_bits(tmo_reg);
        stats.count_seq_errors = low_bits(seq_reg);
        stats.count_stale      = low_bits(stale_reg);
        stats.lat_min          = min_reg;
        stats.lat_max          = max_reg;
        stats.lat_mean         = mean_reg;
        stats.lat_valid        = seen_reg;
    end

endmodule

// ===== hw/rtl/latency_stats_accumulator.sv =====
// Channel  | Dir | Beat contents (low bit up)
// ---------+-----+------------------------------------------------------------
// s_       | in  | tdata: action[2:0], rtt_us[34:3], zero pad to 40 bits
// m_       | out | tdata: six 32-bit counters, lat_min, lat_max, lat_mean (40),
//          |     |        lat_valid, zero pad to 304 bits
//
// Non-sample events and the first sample pass from accept through the exec state to the
// emit state, which loads the output register as the FSM returns to idle and raises s_tready.
// A later sample passes from accept through the exec state, the 40-step radix-2 mean
// divider and the update state before the emit state loads the output register.
// A waiting result holds the FSM in its emit state only while the output register is full.
// Reset (aresetn low, synchronous) clears all counters, the latency state and the FSM.
`include "latency_stats_accumulator_macros.svh"

module latency_stats_accumulator #(
    parameter int FRAC_BITS   = 8,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // action[2:0], rtt_us[34:3]
    input  logic [lsa_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // count_received, count_sent, count_dropped, count_timeouts, count_seq_errors,
    // count_stale, lat_min, lat_max, lat_mean, lat_valid
    output logic [lsa_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready
);

    localparam int ST_W = $bits(lsa_pkg::stats_t);

    lsa_pkg::cmd_t                   cmd;
    lsa_pkg::sts_t                   sts;
    lsa_pkg::stats_t                 stats;
    lsa_pkg::stats_t                 out_view;
    logic                            out_free;
    logic                            lat_fields_zero;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [lsa_pkg::OUT_DATA_W-1:0]  m_tdata_reg, m_tdata_next;

    // The output slot frees when empty or when its beat leaves this cycle.
    assign out_free = !m_tvalid_reg || m_tready;

    lsa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .out_free (out_free),
        .sts      (sts),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    lsa_dp #(
        .FRAC_BITS   (FRAC_BITS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .in_action (s_tdata[lsa_pkg::ACT_W-1:0]),
        .in_rtt    (s_tdata[lsa_pkg::ACT_W +: lsa_pkg::RTT_W]),
        .sts       (sts),
        .stats     (stats)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    // Load a fresh result on emit; otherwise drop valid once the beat is taken.
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (cmd.emit) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = lsa_pkg::OUT_DATA_W'(stats);
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign out_view = lsa_pkg::stats_t'(m_tdata_reg[ST_W-1:0]);

    assign lat_fields_zero = (out_view.lat_min == '0) && (out_view.lat_max == '0)
                             && (out_view.lat_mean == '0);

    // Only one event may be in flight.
    `LSA_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)
    // Before any sample, the latency fields read as zero.
    `LSA_ASSERT_IMPL(a_unset_latency_zero, m_tvalid && !out_view.lat_valid, lat_fields_zero)
    // Once a sample is seen, the minimum never exceeds the maximum.
    `LSA_ASSERT_IMPL(a_min_le_max, m_tvalid && out_view.lat_valid, out_view.lat_min <= out_view.lat_max)

endmodule
